// ===== rtl/core/cscspmv_pkg.sv =====
`default_nettype none

package cscspmv_pkg;

  localparam int MAX_ORDER = 1024;
  localparam int ADDR_W    = $clog2(MAX_ORDER);
  localparam int ORDER_W   = ADDR_W + 1;
  localparam int DATA_W    = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;

  // one product on its way to the accumulator
  typedef struct packed {
    logic              col_end;
    logic [DATA_W-1:0] prod;
  } prod_beat_t;

  // order register clamped to the supported range
  function automatic logic [ORDER_W-1:0] order_in_use(input logic [ORDER_W-1:0] order);
    logic [ORDER_W-1:0] n;
    if (order == '0) begin
      n = ORDER_W'(1);
    end else if (order > ORDER_W'(MAX_ORDER)) begin
      n = ORDER_W'(MAX_ORDER);
    end else begin
      n = order;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cscspmv_accum.sv =====
`default_nettype none

module cscspmv_accum (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [cscspmv_pkg::ORDER_W-1:0]     order,
  input  wire logic                                beat_valid,
  input  wire cscspmv_pkg::prod_beat_t             beat,
  output logic                                     beat_ready,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cscspmv_pkg::ADDR_W-1:0]           column_index,
  output logic [cscspmv_pkg::DATA_W-1:0]           column_sum,
  output logic                                     last_column
);

  logic [cscspmv_pkg::DATA_W-1:0]  sum;
  logic [cscspmv_pkg::DATA_W-1:0]  sum_next;
  logic [cscspmv_pkg::ADDR_W-1:0]  counter;
  logic [cscspmv_pkg::ADDR_W-1:0]  counter_next;
  logic [cscspmv_pkg::ORDER_W-1:0] n;
  logic [cscspmv_pkg::ORDER_W-1:0] counter_ext;
  logic                            is_last;
  logic                            wrap;
  logic                            beat_fire;
  logic                            emit;

  assign n           = cscspmv_pkg::order_in_use(order);
  assign counter_ext = {1'b0, counter};
  assign is_last     = (counter_ext == n - cscspmv_pkg::ORDER_W'(1));
  assign wrap        = ((counter_ext + cscspmv_pkg::ORDER_W'(1)) >= n);

  // a column end needs the output slot, plain entries never wait
  assign beat_ready = !beat.col_end || !out_valid || out_ready;
  assign beat_fire  = beat_valid && beat_ready;
  assign emit       = beat_fire && beat.col_end;

  assign sum_next     = sum + beat.prod;
  assign counter_next = wrap ? '0 : counter + cscspmv_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (beat_fire) begin
        sum <= beat.col_end ? '0 : sum_next;
      end
      if (emit) begin
        counter   <= counter_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      column_index <= counter;
      column_sum   <= sum_next;
      last_column  <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_rose_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(beat_valid && beat.col_end))
    else $error("result appeared without a column end");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    emit |=> (sum == '0))
    else $error("column sum not cleared after emit");

  a_end_waits_slot: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && beat.col_end && out_valid && !out_ready) |-> !beat_ready)
    else $error("column end taken while result slot occupied");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/csc_sparse_matrix_vector_product_top.sv =====
`default_nettype none

// channel   signals                                     direction
// in        in_valid/in_ready, cmd index value column_end   in
// out       out_valid/out_ready, column_index column_sum last_column  out
// cfg       cfg_write, cfg_data (matrix_order)          in
//
// one item per cycle sustained while no column end waits on a stalled output
// path: vector store read, 32x32 multiply, accumulate into out register
// rst clears the pipeline, running sum, column counter and sets matrix_order to 1024
// the vector store is not cleared; entries must only read loaded elements
// a stalled output holds a column end and the items behind it; plain entries still sum

module csc_sparse_matrix_vector_product_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [cscspmv_pkg::ADDR_W-1:0]      index,
  input  wire logic [cscspmv_pkg::DATA_W-1:0]      value,
  input  wire logic                                column_end,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cscspmv_pkg::ADDR_W-1:0]           column_index,
  output logic [cscspmv_pkg::DATA_W-1:0]           column_sum,
  output logic                                     last_column,
  input  wire logic                                cfg_write,
  input  wire logic [cscspmv_pkg::ORDER_W-1:0]     cfg_data
);

  logic [cscspmv_pkg::DATA_W-1:0]   vec_mem [cscspmv_pkg::MAX_ORDER];
  logic [cscspmv_pkg::DATA_W-1:0]   rd_data;
  logic [cscspmv_pkg::ORDER_W-1:0]  order;

  logic                             s1_valid;
  logic [cscspmv_pkg::DATA_W-1:0]   s1_value;
  logic                             s1_end;
  logic                             s2_valid;
  cscspmv_pkg::prod_beat_t          s2_beat;
  logic [cscspmv_pkg::DATA_W-1:0]   full_prod;

  logic in_fire;
  logic load_fire;
  logic entry_fire;
  logic s1_take;
  logic s2_take;
  logic beat_ready;

  assign s2_take    = !s2_valid || beat_ready;
  assign s1_take    = !s1_valid || s2_take;
  assign in_ready   = s1_take;
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (cmd == cscspmv_pkg::CMD_LOAD);
  assign entry_fire = in_fire && (cmd == cscspmv_pkg::CMD_ENTRY);

  // only the low word of the product is kept
  assign full_prod = s1_value * rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= cscspmv_pkg::ORDER_W'(cscspmv_pkg::MAX_ORDER);
    end else if (cfg_write) begin
      order <= cfg_data;
    end
  end

  // vector store: one access per cycle, so read and write never collide
  always_ff @(posedge clk) begin
    if (load_fire) begin
      vec_mem[index] <= value;
    end
    if (entry_fire) begin
      rd_data <= vec_mem[index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= entry_fire;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_fire) begin
      s1_value <= value;
      s1_end   <= column_end;
    end
    if (s2_take && s1_valid) begin
      s2_beat.col_end <= s1_end;
      s2_beat.prod    <= full_prod;
    end
  end

  cscspmv_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .order        (order),
    .beat_valid   (s2_valid),
    .beat         (s2_beat),
    .beat_ready   (beat_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .column_sum   (column_sum),
    .last_column  (last_column)
  );

`ifndef SYNTHESIS
  a_entry_enters: assert property (@(posedge clk) disable iff (rst)
    entry_fire |=> s1_valid)
    else $error("accepted entry lost before multiply stage");

  a_load_no_beat: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> !s1_valid)
    else $error("load produced a pipeline beat");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s2_valid))
    else $error("input stalled with a free pipeline stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/csc_spmv_checker.sv =====
`default_nettype none

module csc_spmv_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic                                cmd,
  input  wire logic [cscspmv_pkg::ADDR_W-1:0]      index,
  input  wire logic [cscspmv_pkg::DATA_W-1:0]      value,
  input  wire logic                                column_end,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic [cscspmv_pkg::ADDR_W-1:0]      column_index,
  input  wire logic [cscspmv_pkg::DATA_W-1:0]      column_sum,
  input  wire logic                                last_column,
  input  wire logic                                cfg_write,
  input  wire logic [cscspmv_pkg::ORDER_W-1:0]     cfg_data,
  output int                                       mismatches,
  output int                                       sums_due,
  output int                                       beats_seen,
  output int                                       columns_seen
);

  import cscspmv_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic [DATA_W-1:0] sum;
    logic              last;
  } column_result_t;

  column_result_t      column_sums_expected[$];
  logic [DATA_W-1:0]   vector_copy [MAX_ORDER];
  logic [DATA_W-1:0]   partial_sum;
  logic [ORDER_W-1:0]  current_column;
  logic [ORDER_W-1:0]  order_reg;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // register value clamped to 1..MAX_ORDER
  function automatic logic [ORDER_W-1:0] columns_in_use();
    if (order_reg == '0) begin
      return ORDER_W'(1);
    end
    if (order_reg > ORDER_W'(MAX_ORDER)) begin
      return ORDER_W'(MAX_ORDER);
    end
    return order_reg;
  endfunction

  task automatic accumulate_beat(input logic c, input logic [ADDR_W-1:0] row,
                                 input logic [DATA_W-1:0] val, input logic done);
    column_result_t      r;
    logic [DATA_W-1:0]   product;
    logic [ORDER_W-1:0]  n;
    if (c == CMD_LOAD) begin
      vector_copy[row] = val;
      return;
    end
    product = val * vector_copy[row];
    partial_sum = partial_sum + product;
    if (!done) begin
      return;
    end
    n = columns_in_use();
    r.col = current_column[ADDR_W-1:0];
    r.sum = partial_sum;
    r.last = (current_column == n - ORDER_W'(1));
    column_sums_expected.push_back(r);
    partial_sum = '0;
    // a counter already past a shrunken order also wraps here
    if (current_column + ORDER_W'(1) >= n) begin
      current_column = '0;
    end else begin
      current_column = current_column + ORDER_W'(1);
    end
  endtask

  task automatic compare_column();
    column_result_t want;
    if (column_sums_expected.size() == 0) begin
      report_mismatch($sformatf("column %0d sum %h arrived with nothing pending",
                                column_index, column_sum));
      return;
    end
    want = column_sums_expected.pop_front();
    if (column_index !== want.col) begin
      report_mismatch($sformatf("column_index %0d, want %0d", column_index, want.col));
    end
    if (column_sum !== want.sum) begin
      report_mismatch($sformatf("column %0d column_sum %h, want %h", want.col, column_sum,
                                want.sum));
    end
    if (last_column !== want.last) begin
      report_mismatch($sformatf("column %0d last_column %b, want %b", want.col,
                                last_column, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      // vector store survives reset, the rest does not
      partial_sum = '0;
      current_column = '0;
      order_reg = ORDER_W'(MAX_ORDER);
      column_sums_expected.delete();
    end else begin
      if (cfg_write) begin
        order_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        columns_seen++;
        compare_column();
      end
      if (in_valid && in_ready) begin
        beats_seen++;
        accumulate_beat(cmd, index, value, column_end);
      end
    end
    sums_due <= column_sums_expected.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

  import cscspmv_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;    // a column sum follows its last entry past s1 and s2
  localparam int IDLE_LIMIT    = 2000;
  localparam int ITEM_TARGET   = 1950;
  localparam int FULL_PHASE    = 3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_LOAD;
  logic [ADDR_W-1:0]  index = '0;
  logic [DATA_W-1:0]  value = '0;
  logic               column_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ADDR_W-1:0]  column_index;
  logic [DATA_W-1:0]  column_sum;
  logic               last_column;
  logic               cfg_write = 1'b0;
  logic [ORDER_W-1:0] cfg_data = '0;

  int mismatches;
  int sums_due;
  int beats_seen;
  int columns_seen;
  int items_sent;
  int orders_written;
  int idle_cycles;
  int ready_hold;
  bit stall_free;
  bit gap_free;
  bit loaded [MAX_ORDER];
  int loaded_rows[$];

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  csc_sparse_matrix_vector_product_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .index        (index),
    .value        (value),
    .column_end   (column_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .column_sum   (column_sum),
    .last_column  (last_column),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  csc_spmv_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .index        (index),
    .value        (value),
    .column_end   (column_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_index (column_index),
    .column_sum   (column_sum),
    .last_column  (last_column),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .sums_due     (sums_due),
    .beats_seen   (beats_seen),
    .columns_seen (columns_seen)
  );

  // receiver stalls: mostly short, a few long, none in stall-free phases
  always @(negedge clk) begin : ready_pattern
    int pick;
    if (stall_free) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(15);
      end else if (pick < 90) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(2);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(50, 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return '0;
    end
    if (pick < 16) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (gap_free) begin
      return 0;
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(50, 10);
  endfunction

  // only rows whose vector element has been loaded
  function automatic logic [ADDR_W-1:0] pick_row();
    return ADDR_W'(loaded_rows[$urandom_range(loaded_rows.size() - 1)]);
  endfunction

  function automatic int pick_entries();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return 0;
    end
    if (pick < 60) begin
      return 1;
    end
    if (pick < 85) begin
      return 2;
    end
    return $urandom_range(6, 3);
  endfunction

  // starts at a falling edge after the previous beat; returns at the accepting edge
  task automatic send_beat(input logic c, input logic [ADDR_W-1:0] row,
                           input logic [DATA_W-1:0] val, input logic done);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    index <= row;
    value <= val;
    column_end <= done;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (c == CMD_LOAD && !loaded[row]) begin
      loaded[row] = 1'b1;
      loaded_rows.push_back(int'(row));
    end
  endtask

  // hold off the sender until every column sum is out and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sums_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] order);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= order;
    @(negedge clk);
    cfg_write <= 1'b0;
    orders_written++;
  endtask

  task automatic stream_column(input int entries);
    int k;
    if (entries == 0) begin
      // empty column goes out as one zero-valued entry
      send_beat(CMD_ENTRY, pick_row(), '0, 1'b1);
      return;
    end
    for (k = 0; k < entries; k++) begin
      if ($urandom_range(19) == 0) begin
        send_beat(CMD_LOAD, ADDR_W'($urandom_range(MAX_ORDER - 1)), pick_word(),
                  1'($urandom_range(1)));
      end
      send_beat(CMD_ENTRY, pick_row(), pick_word(), k == entries - 1);
    end
  endtask

  initial begin
    int phase;
    int cols;
    int sel;
    int k;
    logic [ORDER_W-1:0] order;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, wraparound, empty column, order edge cases
    send_beat(CMD_LOAD, ADDR_W'(0), 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, ADDR_W'(1023), 32'h0000_0001, 1'b1);  // column end ignored on a load
    send_beat(CMD_LOAD, ADDR_W'(1), 32'h1234_5678, 1'b0);
    send_beat(CMD_LOAD, ADDR_W'(2), 32'h0000_0000, 1'b0);
    send_beat(CMD_ENTRY, ADDR_W'(0), 32'hFFFF_FFFF, 1'b0);    // product wraps to 1
    send_beat(CMD_ENTRY, ADDR_W'(1023), 32'hFFFF_FFFF, 1'b0); // sum wraps
    send_beat(CMD_ENTRY, ADDR_W'(1), 32'h9ABC_DEF0, 1'b1);
    send_beat(CMD_ENTRY, ADDR_W'(2), 32'h0000_0000, 1'b1);
    write_order('0);                                          // counter now past the order
    send_beat(CMD_ENTRY, ADDR_W'(0), 32'h0000_0003, 1'b1);
    send_beat(CMD_ENTRY, ADDR_W'(0), 32'h0000_0005, 1'b1);
    write_order(ORDER_W'(3));
    for (k = 0; k < 4; k++) begin
      send_beat(CMD_ENTRY, ADDR_W'(k % 3), DATA_W'(k + 7), 1'b1);
    end
    write_order(ORDER_W'(1));
    send_beat(CMD_ENTRY, ADDR_W'(1023), 32'h0000_0002, 1'b1);
    send_beat(CMD_ENTRY, ADDR_W'(1), 32'h0000_0001, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      stall_free = ($urandom_range(4) == 0);
      gap_free = ($urandom_range(4) == 0);
      if (phase == FULL_PHASE) begin
        // all-ones register clamps to the full order; walk every column at least once
        write_order('1);
        cols = MAX_ORDER + $urandom_range(3);
        for (k = 0; k < cols; k++) begin
          stream_column(($urandom_range(3) == 0) ? 0 : 1);
        end
      end else begin
        sel = $urandom_range(9);
        if (sel == 0) begin
          cols = $urandom_range(12, 1);
        end else begin
          if (sel == 1) begin
            order = ORDER_W'(1);
          end else if (sel == 2) begin
            order = ORDER_W'(MAX_ORDER);
          end else if (sel == 3) begin
            order = ORDER_W'($urandom_range(2047, MAX_ORDER + 1));
          end else begin
            order = ORDER_W'($urandom_range(16, 2));
          end
          write_order(order);
          if (order <= ORDER_W'(16)) begin
            cols = int'(order) * $urandom_range(2, 1) + $urandom_range(1);
          end else begin
            cols = $urandom_range(20, 5);
          end
        end
        repeat ($urandom_range(6, 1)) begin
          send_beat(CMD_LOAD, ADDR_W'($urandom_range(MAX_ORDER - 1)), pick_word(),
                    1'($urandom_range(1)));
        end
        for (k = 0; k < cols; k++) begin
          if ($urandom_range(9) == 0) begin
            settle();
          end
          stream_column(pick_entries());
        end
      end
    end

    settle();
    $display("covered %0d input beats, %0d column sums, %0d order register writes",
             beats_seen, columns_seen, orders_written);
    $display("orders included zero, one, small, full and above the maximum, changed mid-matrix");
    if (mismatches == 0 && sums_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
